// ===== rtl/e2q_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, angle constants and the CORDIC arctangent table for the
// Euler angle to quaternion converter. Depends on nothing.
package e2q_pkg;

  // Port widths.
  localparam int ANGLE_W = 17;
  localparam int QUAT_W  = 16;

  // Internal widths: reduced half angle, CORDIC datapath, sine and cosine
  // with 20 fraction bits, pair products, triple products and output sums.
  localparam int RED_W  = 19;
  localparam int XY_W   = 33;
  localparam int Z_W    = 34;
  localparam int SC_W   = 22;
  localparam int PAIR_W = 44;
  localparam int LO_W   = 21;
  localparam int HI_W   = PAIR_W - LO_W;
  localparam int TRI_W  = 66;
  localparam int SUM_W  = 67;

  // Half angles are in units of 1/256 degree.
  localparam logic signed [RED_W-1:0] HALF_TURN    = 19'sd46080;
  localparam logic signed [RED_W-1:0] FULL_TURN    = 19'sd92160;
  localparam logic signed [RED_W-1:0] QUARTER_TURN = 19'sd23040;

  // Gain-corrected start value of the CORDIC x register, 30 fraction bits.
  localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

  // Rounding constants.
  localparam logic signed [XY_W-1:0]  SC_ROUND  = 33'sd512;
  localparam logic signed [SUM_W-1:0] OUT_ROUND = SUM_W'(64'sd17592186044416);

  // Arctangent of 2^-i in units of 2^-24 degree.
  function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
    logic signed [Z_W-1:0] v;
    begin
      case (idx)
        0:  v = 34'sd754974720;
        1:  v = 34'sd445687602;
        2:  v = 34'sd235489088;
        3:  v = 34'sd119537938;
        4:  v = 34'sd60000934;
        5:  v = 34'sd30029717;
        6:  v = 34'sd15018523;
        7:  v = 34'sd7509720;
        8:  v = 34'sd3754917;
        9:  v = 34'sd1877466;
        10: v = 34'sd938734;
        11: v = 34'sd469367;
        12: v = 34'sd234684;
        13: v = 34'sd117342;
        14: v = 34'sd58671;
        15: v = 34'sd29335;
        16: v = 34'sd14668;
        17: v = 34'sd7334;
        18: v = 34'sd3667;
        19: v = 34'sd1833;
        20: v = 34'sd917;
        21: v = 34'sd458;
        22: v = 34'sd229;
        23: v = 34'sd115;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

// ===== rtl/e2q_sincos.sv =====
`timescale 1ns / 1ps
// Pipelined half-angle sine and cosine: angle reduction, one CORDIC
// iteration per stage, then rounding. Depends on e2q_pkg.
module e2q_sincos #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                 clk,
  input  logic [CORDIC_STAGES+1:0]             en,
  input  logic signed [e2q_pkg::ANGLE_W-1:0]   angle,
  output logic signed [e2q_pkg::SC_W-1:0]      cos_val,
  output logic signed [e2q_pkg::SC_W-1:0]      sin_val
);

  logic signed [e2q_pkg::XY_W-1:0] x [0:CORDIC_STAGES];
  logic signed [e2q_pkg::XY_W-1:0] y [0:CORDIC_STAGES];
  logic signed [e2q_pkg::Z_W-1:0]  z [0:CORDIC_STAGES];
  logic                            flip [0:CORDIC_STAGES];

  logic signed [e2q_pkg::Z_W-1:0] z_init;
  logic                           flip_init;

  // Reduce the half angle into [-90, 90] degrees, noting a half-turn fold.
  always_comb begin
    logic signed [e2q_pkg::RED_W-1:0] a;
    a = e2q_pkg::RED_W'(angle);
    flip_init = 1'b0;
    if (a > e2q_pkg::HALF_TURN) begin
      a = a - e2q_pkg::FULL_TURN;
    end
    if (a < -e2q_pkg::HALF_TURN) begin
      a = a + e2q_pkg::FULL_TURN;
    end
    if (a > e2q_pkg::QUARTER_TURN) begin
      a = a - e2q_pkg::HALF_TURN;
      flip_init = 1'b1;
    end
    if (a < -e2q_pkg::QUARTER_TURN) begin
      a = a + e2q_pkg::HALF_TURN;
      flip_init = 1'b1;
    end
    z_init = e2q_pkg::Z_W'(a) <<< 16;
  end

  // Stage zero holds the reduced angle and the CORDIC start vector.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      x[0]    <= e2q_pkg::CORDIC_GAIN_Q30;
      y[0]    <= '0;
      z[0]    <= z_init;
      flip[0] <= flip_init;
    end
  end

  // One rotation-mode iteration per stage.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    logic signed [e2q_pkg::XY_W-1:0] dx;
    logic signed [e2q_pkg::XY_W-1:0] dy;
    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;

    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        flip[i+1] <= flip[i];
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - dx;
          y[i+1] <= y[i] + dy;
          z[i+1] <= z[i] - e2q_pkg::atan_entry(i);
        end else begin
          x[i+1] <= x[i] + dx;
          y[i+1] <= y[i] - dy;
          z[i+1] <= z[i] + e2q_pkg::atan_entry(i);
        end
      end
    end
  end

  // Round to 20 fraction bits and undo the half-turn fold.
  logic signed [e2q_pkg::XY_W-1:0] x_rnd;
  logic signed [e2q_pkg::XY_W-1:0] y_rnd;
  logic signed [e2q_pkg::SC_W-1:0] c_val;
  logic signed [e2q_pkg::SC_W-1:0] s_val;
  assign x_rnd = x[CORDIC_STAGES] + e2q_pkg::SC_ROUND;
  assign y_rnd = y[CORDIC_STAGES] + e2q_pkg::SC_ROUND;
  assign c_val = $signed(x_rnd[e2q_pkg::SC_W+9:10]);
  assign s_val = $signed(y_rnd[e2q_pkg::SC_W+9:10]);

  always_ff @(posedge clk) begin
    if (en[CORDIC_STAGES+1]) begin
      cos_val <= flip[CORDIC_STAGES] ? -c_val : c_val;
      sin_val <= flip[CORDIC_STAGES] ? -s_val : s_val;
    end
  end

endmodule

// ===== rtl/euler_to_quaternion.sv =====
`timescale 1ns / 1ps
// Roll, pitch and yaw (1/128 degree) to a unit quaternion in Q1.15.
// Uses e2q_pkg and three e2q_sincos pipelines.
//
// Fully pipelined: one beat of angles is taken every cycle unless the input
// is stalled. The pipeline is made of the angle reduction stage, one CORDIC
// iteration per stage, then rounding, a pair-product stage, a split
// triple-product stage, a recombine stage and the output sum, round and
// saturate stage. A stall on the output holds only the stages that are full;
// empty stages keep filling, so bubbles are squeezed out. Results come out
// in input order, one per input beat.
module euler_to_quaternion #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                angle_valid,
  output logic                                angle_stall,
  input  logic signed [e2q_pkg::ANGLE_W-1:0]  roll_angle,
  input  logic signed [e2q_pkg::ANGLE_W-1:0]  pitch_angle,
  input  logic signed [e2q_pkg::ANGLE_W-1:0]  yaw_angle,
  output logic                                quat_valid,
  input  logic                                quat_stall,
  output logic signed [e2q_pkg::QUAT_W-1:0]   quat_w,
  output logic signed [e2q_pkg::QUAT_W-1:0]   quat_x,
  output logic signed [e2q_pkg::QUAT_W-1:0]   quat_y,
  output logic signed [e2q_pkg::QUAT_W-1:0]   quat_z
);

  localparam int PAIR_STG = CORDIC_STAGES + 2;
  localparam int PART_STG = CORDIC_STAGES + 3;
  localparam int TRI_STG  = CORDIC_STAGES + 4;
  localparam int LAST     = CORDIC_STAGES + 5;

  // Which pair product and which yaw term feed each triple product.
  localparam int PAIR_SEL [8] = '{0, 1, 2, 3, 3, 2, 0, 1};
  localparam bit YAW_SIN  [8] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

  logic [LAST:0] vld;
  logic [LAST:0] en;

  // A stage loads when it is empty or the stage after it moves on.
  always_comb begin
    en[LAST] = !vld[LAST] || !quat_stall;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign angle_stall = !en[0];
  assign quat_valid  = vld[LAST];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= angle_valid;
      end
      for (int k = 1; k <= LAST; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Half-angle sine and cosine of each axis.
  logic signed [e2q_pkg::SC_W-1:0] cr, sr, cp, sp, cy, sy;

  e2q_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
    .clk     (clk),
    .en      (en[CORDIC_STAGES+1:0]),
    .angle   (roll_angle),
    .cos_val (cr),
    .sin_val (sr)
  );

  e2q_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk     (clk),
    .en      (en[CORDIC_STAGES+1:0]),
    .angle   (pitch_angle),
    .cos_val (cp),
    .sin_val (sp)
  );

  e2q_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
    .clk     (clk),
    .en      (en[CORDIC_STAGES+1:0]),
    .angle   (yaw_angle),
    .cos_val (cy),
    .sin_val (sy)
  );

  // Roll by pitch pair products; the yaw terms ride along.
  logic signed [e2q_pkg::PAIR_W-1:0] pair [4];
  logic signed [e2q_pkg::SC_W-1:0]   cy_d, sy_d;

  always_ff @(posedge clk) begin
    if (en[PAIR_STG]) begin
      pair[0] <= e2q_pkg::PAIR_W'(cr) * e2q_pkg::PAIR_W'(cp);
      pair[1] <= e2q_pkg::PAIR_W'(sr) * e2q_pkg::PAIR_W'(sp);
      pair[2] <= e2q_pkg::PAIR_W'(sr) * e2q_pkg::PAIR_W'(cp);
      pair[3] <= e2q_pkg::PAIR_W'(cr) * e2q_pkg::PAIR_W'(sp);
      cy_d    <= cy;
      sy_d    <= sy;
    end
  end

  // Each triple product is split into a high and a low partial product.
  logic signed [e2q_pkg::HI_W+e2q_pkg::SC_W-1:0] part_hi [8];
  logic signed [e2q_pkg::LO_W+e2q_pkg::SC_W:0]   part_lo [8];
  logic signed [e2q_pkg::TRI_W-1:0]              tri_p   [8];

  for (genvar j = 0; j < 8; j++) begin : g_tri
    localparam int HP_W = e2q_pkg::HI_W + e2q_pkg::SC_W;
    localparam int LP_W = e2q_pkg::LO_W + e2q_pkg::SC_W + 1;
    logic signed [e2q_pkg::SC_W-1:0]   yaw_term;
    logic signed [e2q_pkg::HI_W-1:0]   p_hi;
    logic signed [e2q_pkg::LO_W:0]     p_lo;
    logic signed [e2q_pkg::PAIR_W-1:0] p_sel;

    assign yaw_term = YAW_SIN[j] ? sy_d : cy_d;
    assign p_sel    = pair[PAIR_SEL[j]];
    assign p_hi     = $signed(p_sel[e2q_pkg::PAIR_W-1:e2q_pkg::LO_W]);
    assign p_lo     = $signed({1'b0, p_sel[e2q_pkg::LO_W-1:0]});

    always_ff @(posedge clk) begin
      if (en[PART_STG]) begin
        part_hi[j] <= HP_W'(p_hi) * HP_W'(yaw_term);
        part_lo[j] <= LP_W'(p_lo) * LP_W'(yaw_term);
      end
    end

    // Recombine the partial products into the full triple product.
    always_ff @(posedge clk) begin
      if (en[TRI_STG]) begin
        tri_p[j] <= (e2q_pkg::TRI_W'(part_hi[j]) <<< e2q_pkg::LO_W)
                    + e2q_pkg::TRI_W'(part_lo[j]);
      end
    end
  end

  // Round a sum with 60 fraction bits to Q1.15 and saturate.
  function automatic logic signed [e2q_pkg::QUAT_W-1:0] to_q15(
    input logic signed [e2q_pkg::SUM_W-1:0] v
  );
    logic signed [e2q_pkg::SUM_W-1:0] r;
    logic signed [e2q_pkg::SUM_W-46:0] q;
    begin
      r = v + e2q_pkg::OUT_ROUND;
      q = $signed(r[e2q_pkg::SUM_W-1:45]);
      if (q > 32767) begin
        return 16'sh7FFF;
      end else if (q < -32768) begin
        return 16'sh8000;
      end
      return q[e2q_pkg::QUAT_W-1:0];
    end
  endfunction

  // Form the four quaternion parts in the output register.
  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      quat_w <= to_q15(e2q_pkg::SUM_W'(tri_p[0]) + e2q_pkg::SUM_W'(tri_p[1]));
      quat_x <= to_q15(e2q_pkg::SUM_W'(tri_p[2]) - e2q_pkg::SUM_W'(tri_p[3]));
      quat_y <= to_q15(e2q_pkg::SUM_W'(tri_p[4]) + e2q_pkg::SUM_W'(tri_p[5]));
      quat_z <= to_q15(e2q_pkg::SUM_W'(tri_p[6]) - e2q_pkg::SUM_W'(tri_p[7]));
    end
  end

endmodule

// ===== rtl/e2q_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for euler_to_quaternion, attached with a bind.
// Depends on e2q_pkg for the port widths.
module e2q_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                angle_valid,
  input logic                                angle_stall,
  input logic signed [e2q_pkg::ANGLE_W-1:0]  roll_angle,
  input logic signed [e2q_pkg::ANGLE_W-1:0]  pitch_angle,
  input logic signed [e2q_pkg::ANGLE_W-1:0]  yaw_angle,
  input logic                                quat_valid,
  input logic                                quat_stall,
  input logic signed [e2q_pkg::QUAT_W-1:0]   quat_w,
  input logic signed [e2q_pkg::QUAT_W-1:0]   quat_x,
  input logic signed [e2q_pkg::QUAT_W-1:0]   quat_y,
  input logic signed [e2q_pkg::QUAT_W-1:0]   quat_z
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !quat_valid)
    else $error("output beat present right after reset");

  // A stalled input beat holds its angles.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (angle_valid && angle_stall) |=> (angle_valid && $stable(roll_angle)
                                      && $stable(pitch_angle) && $stable(yaw_angle)))
    else $error("stalled input beat changed");

  // A stalled result beat holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (quat_valid && quat_stall) |=> (quat_valid && $stable(quat_w) && $stable(quat_x)
                                    && $stable(quat_y) && $stable(quat_z)))
    else $error("stalled output beat changed");

  // With the output draining, the input never stalls.
  a_no_stall: assert property (@(posedge clk) !quat_stall |-> !angle_stall)
    else $error("input stalled while output drains");

  // The input stalls only when the output is backed up.
  a_stall_cause: assert property (@(posedge clk)
    angle_stall |-> (quat_valid && quat_stall))
    else $error("input stalled without output back-pressure");

endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (.*);
